// File: rtl/alm_pkg.sv
// Shared constants and codes for the array linked list manager.
package alm_pkg;

  localparam int CAPACITY = 255;
  localparam int SLOT_W   = 8;
  localparam int DEPTH    = 2 ** SLOT_W;
  localparam int VALUE_W  = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = $clog2(CAPACITY + 1) + 1;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [COUNT_W-1:0]  count_t;

  localparam op_t OP_INS_AFTER  = 2'd0;
  localparam op_t OP_INS_BEFORE = 2'd1;
  localparam op_t OP_DELETE     = 2'd2;
  localparam op_t OP_NONE       = 2'd3;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_RANGE    = 3'd2;
  localparam status_t ST_UNLINKED = 3'd3;
  localparam status_t ST_SENTINEL = 3'd4;

endpackage

// File: rtl/array_linked_list_manager.sv
// Doubly linked list over a fixed node pool with a free chain, slot 0 as sentinel.
//
// Requests come in on the s_ channel: tuser carries the operation (insert after,
// insert before, delete), tdata the anchor slot and the data word. Each request
// gives one result transfer on the m_ channel: the slot taken by an insert and a
// status code (ok, pool full, index out of range, anchor not linked, sentinel
// delete).
// A request that is refused, or an unused op code, returns its result in the cycle
// after the transfer and leaves the list untouched. A good request runs through a
// small sequencer around the next and prev link memories, one read and one write
// port each: read states S_RD1 and S_RD2, then write states S_WR1 and S_WR2; the
// result is registered at the end of S_WR2, and no new request is taken before the
// sequencer is back in S_IDLE. The link memories set the pace: an insert needs two
// reads of the next memory and two writes to each memory.
// s_tready is low while a request is in work and while a result waits for the
// receiver; a stalled result holds in the output register.
// Reset clears the link state at once: untouched slots read their reset links
// through a high-water mark, so there is no clearing pass.
module array_linked_list_manager (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // [7:0] anchor, [39:8] value
  input  logic [1:0]  s_tuser,  // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // [7:0] new_slot, [10:8] status, [15:11] zero
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_WR1  = 3'd3;
  localparam logic [2:0] S_WR2  = 3'd4;

  localparam alm_pkg::slot_t LAST_SLOT = alm_pkg::SLOT_W'(alm_pkg::CAPACITY);

  logic [2:0] state;

  logic [alm_pkg::VALUE_W-1:0] value_mem [alm_pkg::DEPTH];
  alm_pkg::slot_t next_mem [alm_pkg::DEPTH];
  alm_pkg::slot_t prev_mem [alm_pkg::DEPTH];

  logic [alm_pkg::DEPTH-1:0] linked;
  alm_pkg::slot_t  free_head;
  alm_pkg::count_t used_count;
  alm_pkg::slot_t  high_water;
  alm_pkg::slot_t  sent_next;
  alm_pkg::slot_t  sent_prev;

  alm_pkg::op_t   op_r;
  alm_pkg::slot_t anchor_r;
  alm_pkg::slot_t slot_r;
  alm_pkg::slot_t n_r;
  alm_pkg::slot_t p_r;
  alm_pkg::slot_t fnext_r;
  logic [alm_pkg::VALUE_W-1:0] value_r;

  alm_pkg::slot_t    out_slot;
  alm_pkg::status_t  out_status;

  alm_pkg::slot_t nx_ra, nx_ra_q, nx_q, nx_wa, nx_wd;
  alm_pkg::slot_t pv_ra, pv_ra_q, pv_q, pv_wa, pv_wd;
  logic nx_we, pv_we;

  alm_pkg::slot_t next_val, prev_val;

  alm_pkg::op_t   in_op;
  alm_pkg::slot_t in_anchor;
  alm_pkg::status_t in_status;
  logic in_go;
  logic accept;

  assign in_op     = s_tuser;
  assign in_anchor = s_tdata[7:0];
  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign m_tdata   = {5'd0, out_status, out_slot};

  always_comb begin
    in_status = alm_pkg::ST_OK;
    in_go     = 1'b0;
    priority if (in_op == alm_pkg::OP_NONE) begin
      in_status = alm_pkg::ST_OK;
    end else if (int'(in_anchor) > alm_pkg::CAPACITY) begin
      in_status = alm_pkg::ST_RANGE;
    end else if (in_op == alm_pkg::OP_DELETE && in_anchor == '0) begin
      in_status = alm_pkg::ST_SENTINEL;
    end else if (!linked[in_anchor]) begin
      in_status = alm_pkg::ST_UNLINKED;
    end else if (in_op == alm_pkg::OP_DELETE) begin
      in_go = 1'b1;
    end else if (used_count >= alm_pkg::COUNT_W'(alm_pkg::CAPACITY)) begin
      in_status = alm_pkg::ST_FULL;
    end else begin
      in_go = 1'b1;
    end
  end

  // untouched slots above the high-water mark still hold their reset links
  always_comb begin
    priority if (nx_ra_q == '0) begin
      next_val = sent_next;
    end else if (nx_ra_q > high_water) begin
      next_val = (nx_ra_q == LAST_SLOT) ? '0 : nx_ra_q + 1'b1;
    end else begin
      next_val = nx_q;
    end
    prev_val = (pv_ra_q == '0) ? sent_prev : pv_q;
  end

  always_comb begin
    nx_ra = anchor_r;
    pv_ra = anchor_r;
    nx_we = 1'b0;
    nx_wa = slot_r;
    nx_wd = n_r;
    pv_we = 1'b0;
    pv_wa = slot_r;
    pv_wd = anchor_r;
    unique case (state)
      S_RD2: begin
        nx_ra = slot_r;
      end
      S_WR1: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
        unique case (op_r)
          alm_pkg::OP_INS_AFTER: begin
            nx_wa = slot_r;
            nx_wd = n_r;
            pv_wa = slot_r;
            pv_wd = anchor_r;
          end
          alm_pkg::OP_INS_BEFORE: begin
            nx_wa = slot_r;
            nx_wd = anchor_r;
            pv_wa = slot_r;
            pv_wd = p_r;
          end
          default: begin
            nx_wa = p_r;
            nx_wd = n_r;
            pv_wa = n_r;
            pv_wd = p_r;
          end
        endcase
      end
      S_WR2: begin
        nx_we = 1'b1;
        unique case (op_r)
          alm_pkg::OP_INS_AFTER: begin
            nx_wa = anchor_r;
            nx_wd = slot_r;
            pv_we = 1'b1;
            pv_wa = n_r;
            pv_wd = slot_r;
          end
          alm_pkg::OP_INS_BEFORE: begin
            nx_wa = p_r;
            nx_wd = slot_r;
            pv_we = 1'b1;
            pv_wa = anchor_r;
            pv_wd = slot_r;
          end
          default: begin
            nx_wa = anchor_r;
            nx_wd = free_head;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    if (state == S_WR1 && op_r != alm_pkg::OP_DELETE) begin
      value_mem[slot_r] <= value_r;
    end
    nx_q    <= next_mem[nx_ra];
    pv_q    <= prev_mem[pv_ra];
    nx_ra_q <= nx_ra;
    pv_ra_q <= pv_ra;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      anchor_r <= in_anchor;
      value_r  <= s_tdata[39:8];
      slot_r   <= free_head;
    end
    if (state == S_RD2) begin
      n_r <= next_val;
      p_r <= prev_val;
    end
    if (state == S_WR1) begin
      fnext_r <= next_val;
    end
    if (accept && !in_go) begin
      out_slot   <= '0;
      out_status <= in_status;
    end else if (state == S_WR2) begin
      out_slot   <= (op_r == alm_pkg::OP_DELETE) ? '0 : slot_r;
      out_status <= alm_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      linked     <= alm_pkg::DEPTH'(1);
      free_head  <= alm_pkg::SLOT_W'(1);
      used_count <= '0;
      high_water <= '0;
      sent_next  <= '0;
      sent_prev  <= '0;
    end else begin
      if (nx_we && nx_wa == '0) begin
        sent_next <= nx_wd;
      end
      if (pv_we && pv_wa == '0) begin
        sent_prev <= pv_wd;
      end
      if ((accept && !in_go) || state == S_WR2) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && in_go) begin
            state <= S_RD1;
          end
        end
        S_RD1: begin
          state <= S_RD2;
        end
        S_RD2: begin
          state <= S_WR1;
        end
        S_WR1: begin
          state <= S_WR2;
        end
        S_WR2: begin
          state <= S_IDLE;
          if (op_r == alm_pkg::OP_DELETE) begin
            linked[anchor_r] <= 1'b0;
            free_head        <= anchor_r;
            used_count       <= used_count - 1'b1;
          end else begin
            linked[slot_r] <= 1'b1;
            free_head      <= fnext_r;
            used_count     <= used_count + 1'b1;
            if (slot_r > high_water) begin
              high_water <= slot_r;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    used_count <= alm_pkg::COUNT_W'(alm_pkg::CAPACITY))
    else $error("used count above capacity");

  a_free_head : assert property (@(posedge clk) disable iff (rst)
    (used_count != alm_pkg::COUNT_W'(alm_pkg::CAPACITY)) |-> (free_head != '0))
    else $error("free chain empty while pool not full");

  a_new_linked : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == alm_pkg::ST_OK && out_slot != '0) |-> linked[out_slot])
    else $error("reported slot not linked");

endmodule

// File: dv/tb_array_linked_list_manager.sv
// Self-checking testbench for the array linked list manager: directed table, then random phases.
module tb_array_linked_list_manager;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

  typedef struct packed {
    alm_pkg::slot_t   slot;
    alm_pkg::status_t status;
  } result_t;

  typedef struct packed {
    alm_pkg::op_t                op;
    alm_pkg::slot_t              anchor;
    logic [alm_pkg::VALUE_W-1:0] value;
    bit                          typed;
    alm_pkg::slot_t              exp_slot;
    alm_pkg::status_t            exp_status;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [7:0] anchor, [39:8] value
  logic [1:0]  s_tuser;   // [1:0] op
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [7:0] new_slot, [10:8] status, [15:11] zero

  array_linked_list_manager uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // List state mirror
  alm_pkg::slot_t  link_next [alm_pkg::DEPTH];
  alm_pkg::slot_t  link_prev [alm_pkg::DEPTH];
  bit              in_list   [alm_pkg::DEPTH];
  alm_pkg::slot_t  free_head;
  int              used_count;
  int              peak_used;

  result_t pending_results[$];
  int      errors;
  int      send_idle_pct;
  int      stall_pct;
  int      status_hits [8];
  int      requests;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void list_reset();
    for (int i = 0; i < alm_pkg::DEPTH; i++) begin
      link_next[i] = (i < alm_pkg::CAPACITY) ? alm_pkg::slot_t'(i + 1) : '0;
      link_prev[i] = '0;
      in_list[i]   = 1'b0;
    end
    link_next[0] = '0;
    in_list[0]   = 1'b1;
    free_head    = alm_pkg::slot_t'(1);
    used_count   = 0;
    peak_used    = 0;
  endfunction

  function automatic alm_pkg::slot_t take_slot();
    alm_pkg::slot_t s;
    s = free_head;
    free_head = link_next[s];
    used_count++;
    in_list[s] = 1'b1;
    if (used_count > peak_used) peak_used = used_count;
    return s;
  endfunction

  function automatic result_t list_apply(alm_pkg::op_t op, alm_pkg::slot_t a);
    result_t        r;
    alm_pkg::slot_t n;
    alm_pkg::slot_t p;
    r.slot   = '0;
    r.status = alm_pkg::ST_OK;
    if (op == alm_pkg::OP_NONE) begin
    end else if (int'(a) > alm_pkg::CAPACITY) begin
      r.status = alm_pkg::ST_RANGE;
    end else if (op == alm_pkg::OP_DELETE && a == '0) begin
      r.status = alm_pkg::ST_SENTINEL;
    end else if (!in_list[a]) begin
      r.status = alm_pkg::ST_UNLINKED;
    end else if (op == alm_pkg::OP_DELETE) begin
      n = link_next[a];
      p = link_prev[a];
      link_prev[n] = p;
      link_next[p] = n;
      link_next[a] = free_head;
      link_prev[a] = '0;
      in_list[a]   = 1'b0;
      free_head    = a;
      used_count--;
    end else if (used_count >= alm_pkg::CAPACITY) begin
      r.status = alm_pkg::ST_FULL;
    end else if (op == alm_pkg::OP_INS_AFTER) begin
      n = link_next[a];
      r.slot = take_slot();
      link_next[r.slot] = n;
      link_prev[r.slot] = a;
      link_next[a] = r.slot;
      link_prev[n] = r.slot;
    end else begin
      p = link_prev[a];
      r.slot = take_slot();
      link_prev[r.slot] = p;
      link_next[r.slot] = a;
      link_prev[a] = r.slot;
      link_next[p] = r.slot;
    end
    status_hits[r.status]++;
    requests++;
    return r;
  endfunction

  function automatic alm_pkg::slot_t pick_linked(bit skip_sentinel);
    int total;
    int k;
    total = skip_sentinel ? used_count : used_count + 1;
    if (total == 0) return '0;
    k = $urandom_range(0, total - 1);
    for (int i = skip_sentinel ? 1 : 0; i < alm_pkg::DEPTH; i++) begin
      if (in_list[i]) begin
        if (k == 0) return alm_pkg::slot_t'(i);
        k--;
      end
    end
    return '0;
  endfunction

  // Drive one request; the expectation is queued at the accepting edge.
  task automatic send_request(alm_pkg::op_t op, alm_pkg::slot_t anchor,
                              logic [alm_pkg::VALUE_W-1:0] value,
                              bit typed, result_t typed_res);
    result_t r;
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = {$urandom, 8'($urandom)};
      s_tuser  = 2'($urandom);
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {value, anchor};
    do @(posedge clk); while (!s_tready);
    r = list_apply(op, anchor);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_request(mix_t mix);
    int             roll;
    alm_pkg::op_t   op;
    alm_pkg::slot_t a;
    roll = $urandom_range(1, 100);
    case (mix)
      MIX_FILL: begin
        op = (roll <= 2) ? alm_pkg::OP_NONE : (roll <= 5) ? alm_pkg::OP_DELETE :
             (roll <= 52) ? alm_pkg::OP_INS_AFTER : alm_pkg::OP_INS_BEFORE;
      end
      MIX_DRAIN: begin
        op = (roll <= 3) ? alm_pkg::OP_NONE : (roll <= 80) ? alm_pkg::OP_DELETE :
             (roll <= 90) ? alm_pkg::OP_INS_AFTER : alm_pkg::OP_INS_BEFORE;
      end
      default: begin
        op = (roll <= 4) ? alm_pkg::OP_NONE : (roll <= 36) ? alm_pkg::OP_DELETE :
             (roll <= 68) ? alm_pkg::OP_INS_AFTER : alm_pkg::OP_INS_BEFORE;
      end
    endcase
    if ($urandom_range(1, 100) <= 80)
      a = pick_linked(op == alm_pkg::OP_DELETE);
    else
      a = alm_pkg::slot_t'($urandom_range(0, alm_pkg::DEPTH - 1));
    send_request(op, a, $urandom, 1'b0, '0);
  endtask

  always @(negedge clk) begin
    m_tready = (stall_pct == 0) || ($urandom_range(1, 100) > stall_pct);
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer %h", $realtime, m_tdata);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (m_tdata[7:0] !== e.slot) begin
          $display("%0t: new_slot expected %0d actual %0d", $realtime, e.slot, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[10:8] !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, e.status,
                   m_tdata[10:8]);
          errors++;
        end
        if (m_tdata[15:11] !== 5'd0) begin
          $display("%0t: pad bits expected 0 actual %h", $realtime, m_tdata[15:11]);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_array_linked_list_manager NOT OK");
    $finish;
  end

  initial begin : main
    dir_row_t dir_rows [20];
    int       ph_items [4];
    int       ph_idle  [4];
    int       ph_stall [4];
    mix_t     ph_mix   [4];

    // Range errors cannot arise here: an 8-bit anchor never exceeds CAPACITY.
    dir_rows = '{
      '{alm_pkg::OP_INS_AFTER,  8'd0,   32'h7FFF_FFFF, 1'b1, 8'd1, alm_pkg::ST_OK},
      '{alm_pkg::OP_DELETE,     8'd0,   32'h0,         1'b1, 8'd0, alm_pkg::ST_SENTINEL},
      '{alm_pkg::OP_DELETE,     8'd5,   32'h0,         1'b1, 8'd0, alm_pkg::ST_UNLINKED},
      '{alm_pkg::OP_INS_BEFORE, 8'd9,   32'h1234_5678, 1'b1, 8'd0, alm_pkg::ST_UNLINKED},
      '{alm_pkg::OP_INS_AFTER,  8'd255, 32'hFFFF_FFFF, 1'b1, 8'd0, alm_pkg::ST_UNLINKED},
      '{alm_pkg::OP_NONE,       8'd200, 32'hDEAD_BEEF, 1'b1, 8'd0, alm_pkg::ST_OK},
      '{alm_pkg::OP_INS_BEFORE, 8'd0,   32'h8000_0000, 1'b1, 8'd2, alm_pkg::ST_OK},
      '{alm_pkg::OP_INS_AFTER,  8'd1,   32'h0,         1'b1, 8'd3, alm_pkg::ST_OK},
      '{alm_pkg::OP_INS_BEFORE, 8'd1,   32'hFFFF_FFFF, 1'b0, 8'd0, alm_pkg::ST_OK},
      '{alm_pkg::OP_DELETE,     8'd1,   32'h0,         1'b0, 8'd0, alm_pkg::ST_OK},
      '{alm_pkg::OP_DELETE,     8'd1,   32'h0,         1'b1, 8'd0, alm_pkg::ST_UNLINKED},
      '{alm_pkg::OP_INS_AFTER,  8'd4,   32'h1,         1'b0, 8'd0, alm_pkg::ST_OK},
      '{alm_pkg::OP_DELETE,     8'd2,   32'h0,         1'b0, 8'd0, alm_pkg::ST_OK},
      '{alm_pkg::OP_DELETE,     8'd3,   32'h0,         1'b0, 8'd0, alm_pkg::ST_OK},
      '{alm_pkg::OP_INS_BEFORE, 8'd0,   32'h5555_5555, 1'b0, 8'd0, alm_pkg::ST_OK},
      '{alm_pkg::OP_INS_AFTER,  8'd0,   32'hAAAA_AAAA, 1'b0, 8'd0, alm_pkg::ST_OK},
      '{alm_pkg::OP_DELETE,     8'd0,   32'hFFFF_FFFF, 1'b1, 8'd0, alm_pkg::ST_SENTINEL},
      '{alm_pkg::OP_NONE,       8'd0,   32'h0,         1'b1, 8'd0, alm_pkg::ST_OK},
      '{alm_pkg::OP_DELETE,     8'd4,   32'h0,         1'b0, 8'd0, alm_pkg::ST_OK},
      '{alm_pkg::OP_INS_BEFORE, 8'd3,   32'h0F0F_0F0F, 1'b0, 8'd0, alm_pkg::ST_OK}
    };
    ph_items = '{80, 290, 110, 80};
    ph_idle  = '{0, 50, 0, 6};
    ph_stall = '{0, 0, 50, 6};
    ph_mix   = '{MIX_BALANCED, MIX_FILL, MIX_DRAIN, MIX_BALANCED};

    errors        = 0;
    requests      = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    m_tready = 1'b0;
    list_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].op, dir_rows[i].anchor, dir_rows[i].value, dir_rows[i].typed,
                   '{dir_rows[i].exp_slot, dir_rows[i].exp_status});
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = ph_idle[ph];
      stall_pct     = ph_stall[ph];
      for (int n = 0; n < ph_items[ph]; n++) random_request(ph_mix[ph]);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d requests: %0d ok, %0d pool full, %0d not linked, %0d sentinel deletes",
             requests, status_hits[alm_pkg::ST_OK], status_hits[alm_pkg::ST_FULL],
             status_hits[alm_pkg::ST_UNLINKED], status_hits[alm_pkg::ST_SENTINEL]);
    $display("Peak occupancy %0d of %0d slots, over idle, stall and mixed phases",
             peak_used, alm_pkg::CAPACITY);
    if (errors == 0) begin
      $display("tb_array_linked_list_manager OK");
    end else begin
      $display("tb_array_linked_list_manager NOT OK");
    end
    $finish;
  end

endmodule
